### src/sucb_pkg.sv
// Shared types and constants for the segment unit-box crop block.
package sucb_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    KIND_OUTSIDE    = 3'd0,
    KIND_INSIDE     = 3'd1,
    KIND_CROP_START = 3'd2,
    KIND_CROP_END   = 3'd3,
    KIND_CROSS      = 3'd4
  } crop_kind_t;

  typedef logic [1:0] edge_t;

  localparam edge_t EDGE_TOP    = 2'd0;
  localparam edge_t EDGE_RIGHT  = 2'd1;
  localparam edge_t EDGE_BOTTOM = 2'd2;
  localparam edge_t EDGE_LEFT   = 2'd3;

  // edge pairs compared by the sorter
  localparam int NPAIR = 6;
  localparam edge_t PAIR_A [NPAIR] = '{EDGE_TOP, EDGE_TOP, EDGE_TOP,
                                       EDGE_RIGHT, EDGE_RIGHT, EDGE_BOTTOM};
  localparam edge_t PAIR_B [NPAIR] = '{EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT,
                                       EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};

endpackage

### src/sucb_along.sv
// Pipelined base + round(num*mul/den) unit with saturation, one request per cycle while en is high.
module sucb_along
  import sucb_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF,
  parameter int TW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [TW-1:0]        in_tag,
  input  logic signed [CW-1:0] base,
  input  logic signed [CW+1:0] num,
  input  logic signed [CW+1:0] mul,
  input  logic signed [CW+1:0] den,
  output logic                 out_valid,
  output logic [TW-1:0]        out_tag,
  output logic signed [CW-1:0] result
);

  localparam int NW = CW + 2;
  localparam int PW = 2 * NW;
  localparam int XW = (PW + 1 > 64) ? PW + 1 : 64;
  localparam logic [XW-1:0] QCLAMP = XW'(1) << 62;
  localparam logic signed [XW:0] SMAX = {{(XW - CW + 2){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [XW:0] SMIN = ~SMAX;

  // magnitude stage
  logic                 vm_r;
  logic [NW-1:0]        mn_r, mm_r, md_r;
  logic                 negm_r, dzm_r;
  logic signed [CW-1:0] bm_r;
  logic [TW-1:0]        tm_r;

  // divider stages, index 0 holds the product
  logic                 vd_r   [0:PW];
  logic [NW-1:0]        rem_r  [0:PW];
  logic [PW-1:0]        quo_r  [0:PW];
  logic [PW-1:0]        prd_r  [0:PW];
  logic [NW-1:0]        dv_r   [0:PW];
  logic                 negd_r [0:PW];
  logic                 dzd_r  [0:PW];
  logic signed [CW-1:0] bd_r   [0:PW];
  logic [TW-1:0]        td_r   [0:PW];

  // rounding and output stages
  logic                 vf_r, dzf_r;
  logic signed [XW:0]   qs_r;
  logic signed [CW-1:0] bf_r;
  logic [TW-1:0]        tf_r;
  logic                 vo_r;
  logic [TW-1:0]        to_r;
  logic signed [CW-1:0] res_r;

  logic                 rnd;
  logic [XW-1:0]        qr, qc;
  logic signed [XW:0]   qs_nxt;
  logic signed [XW:0]   sum;
  logic signed [CW-1:0] res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vf_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= PW; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vm_r <= in_valid;
      vd_r[0] <= vm_r;
      for (int k = 1; k <= PW; k++) vd_r[k] <= vd_r[k-1];
      vf_r <= vd_r[PW];
      vo_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn_r   <= num[NW-1] ? $unsigned(-num) : $unsigned(num);
      mm_r   <= mul[NW-1] ? $unsigned(-mul) : $unsigned(mul);
      md_r   <= den[NW-1] ? $unsigned(-den) : $unsigned(den);
      negm_r <= (num[NW-1] ^ mul[NW-1]) ^ den[NW-1];
      dzm_r  <= (den == '0);
      bm_r   <= base;
      tm_r   <= in_tag;

      prd_r[0]  <= PW'(mn_r) * PW'(mm_r);
      rem_r[0]  <= '0;
      quo_r[0]  <= '0;
      dv_r[0]   <= md_r;
      negd_r[0] <= negm_r;
      dzd_r[0]  <= dzm_r;
      bd_r[0]   <= bm_r;
      td_r[0]   <= tm_r;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= PW; k++) begin : g_div
    logic [NW:0] sh, df;
    logic        ge;
    assign sh = {rem_r[k-1], prd_r[k-1][PW-1]};
    assign df = sh - {1'b0, dv_r[k-1]};
    assign ge = sh >= {1'b0, dv_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? df[NW-1:0] : sh[NW-1:0];
        quo_r[k]  <= {quo_r[k-1][PW-2:0], ge};
        prd_r[k]  <= prd_r[k-1] << 1;
        dv_r[k]   <= dv_r[k-1];
        negd_r[k] <= negd_r[k-1];
        dzd_r[k]  <= dzd_r[k-1];
        bd_r[k]   <= bd_r[k-1];
        td_r[k]   <= td_r[k-1];
      end
    end
  end

  // round half away from zero, clamp, apply sign
  always_comb begin
    rnd    = {rem_r[PW], 1'b0} >= {1'b0, dv_r[PW]};
    qr     = XW'(quo_r[PW]) + XW'(rnd);
    qc     = (qr > QCLAMP) ? QCLAMP : qr;
    qs_nxt = negd_r[PW] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

  // add base and saturate
  always_comb begin
    sum = (XW + 1)'(bf_r) + (dzf_r ? '0 : qs_r);
    if (sum > SMAX)      res_nxt = SMAX[CW-1:0];
    else if (sum < SMIN) res_nxt = SMIN[CW-1:0];
    else                 res_nxt = sum[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs_r  <= qs_nxt;
      dzf_r <= dzd_r[PW];
      bf_r  <= bd_r[PW];
      tf_r  <= td_r[PW];
      res_r <= res_nxt;
      to_r  <= tf_r;
    end
  end

  assign out_valid = vo_r;
  assign out_tag   = to_r;
  assign result    = res_r;

endmodule

### src/segment_unit_box_crop_core.sv
// Top level of the segment unit-box crop block.
// Usage:
//  - Slave channel (in_*): one request per segment, start_x, start_y, end_x, end_y,
//    signed fixed point with FRAC_BITS fraction bits.
//  - Master channel (out_*): one result per request, crop kind plus one or two
//    boundary points on the open unit square; unused points read as zero.
//  - Throughput: one request per cycle, sustained while the receiver accepts.
//  - Depth: two chained divider pipelines, each 2*(COORD_BITS+2) bit stages deep
//    plus magnitude, product, rounding and saturation stages.
//  - Pipeline: classify, edge-parameter normalize, cross products, sort and
//    argument select, first divider, cut check and second-cut select, second
//    divider, output register.
//  - Reset clears every valid bit; payload registers are not reset.
//  - When the receiver stalls, the whole pipeline holds and in_tready drops in
//    the same cycle; no request is lost or repeated.
module segment_unit_box_crop_core
  import sucb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // start_x, start_y, end_x, end_y, zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // crop_kind, first_cut_x, first_cut_y, second_cut_x, second_cut_y, zero padded
  output logic [((4*COORD_BITS+10)/8)*8-1:0] out_tdata
);

  localparam int CW  = COORD_BITS;
  localparam int NW  = CW + 2;
  localparam int ODW = ((4 * CW + 10) / 8) * 8;
  localparam int T0W = 3 + 2 * CW + 2 * NW + 6;
  localparam int T2W = 3 + 4 * CW + 2;
  localparam logic signed [NW-1:0] UNITV  = NW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] UNIT_C = UNITV[CW-1:0];

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: classify, pick outer point, run vector
  logic                 s1_v_r;
  crop_kind_t           s1_kind_r;
  logic signed [NW-1:0] s1_px_r, s1_py_r, s1_rx_r, s1_ry_r;

  logic signed [NW-1:0] ax, ay, cx, cy;
  logic                 outside, ain, cin;
  crop_kind_t           kind1;

  always_comb begin
    ax = NW'($signed(in_tdata[CW-1:0]));
    ay = NW'($signed(in_tdata[2*CW-1:CW]));
    cx = NW'($signed(in_tdata[3*CW-1:2*CW]));
    cy = NW'($signed(in_tdata[4*CW-1:3*CW]));
    outside = (ax <= 0 && cx <= 0) || (ax >= UNITV && cx >= UNITV) ||
              (ay <= 0 && cy <= 0) || (ay >= UNITV && cy >= UNITV);
    ain = ax > 0 && ax < UNITV && ay > 0 && ay < UNITV;
    cin = cx > 0 && cx < UNITV && cy > 0 && cy < UNITV;
    if (outside)         kind1 = KIND_OUTSIDE;
    else if (ain && cin) kind1 = KIND_INSIDE;
    else if (ain)        kind1 = KIND_CROP_START;
    else if (cin)        kind1 = KIND_CROP_END;
    else                 kind1 = KIND_CROSS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= kind1;
      // cropped at start: the end point is the outer one
      if (kind1 == KIND_CROP_START) begin
        s1_px_r <= cx;
        s1_py_r <= cy;
        s1_rx_r <= ax - cx;
        s1_ry_r <= ay - cy;
      end else begin
        s1_px_r <= ax;
        s1_py_r <= ay;
        s1_rx_r <= cx - ax;
        s1_ry_r <= cy - ay;
      end
    end
  end

  // ---------------- stage 2: edge parameters with non-negative denominators
  logic                 s2_v_r;
  crop_kind_t           s2_kind_r;
  logic signed [NW-1:0] s2_px_r, s2_py_r, s2_rx_r, s2_ry_r;
  logic signed [NW-1:0] s2_n_r [4];
  logic signed [NW-1:0] s2_d_r [4];

  logic signed [NW-1:0] nraw [4];
  logic signed [NW-1:0] draw [4];

  always_comb begin
    nraw[EDGE_TOP]    = UNITV - s1_py_r;
    draw[EDGE_TOP]    = s1_ry_r;
    nraw[EDGE_RIGHT]  = UNITV - s1_px_r;
    draw[EDGE_RIGHT]  = s1_rx_r;
    nraw[EDGE_BOTTOM] = -s1_py_r;
    draw[EDGE_BOTTOM] = s1_ry_r;
    nraw[EDGE_LEFT]   = -s1_px_r;
    draw[EDGE_LEFT]   = s1_rx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_kind_r;
      s2_px_r   <= s1_px_r;
      s2_py_r   <= s1_py_r;
      s2_rx_r   <= s1_rx_r;
      s2_ry_r   <= s1_ry_r;
      for (int e = 0; e < 4; e++) begin
        s2_n_r[e] <= (draw[e] < 0) ? -nraw[e] : nraw[e];
        s2_d_r[e] <= (draw[e] < 0) ? -draw[e] : draw[e];
      end
    end
  end

  // ---------------- stage 3: cross products for the edge sort
  logic                   s3_v_r;
  crop_kind_t             s3_kind_r;
  logic signed [NW-1:0]   s3_px_r, s3_py_r, s3_rx_r, s3_ry_r;
  logic signed [NW-1:0]   s3_n_r [4];
  logic signed [NW-1:0]   s3_d_r [4];
  logic signed [2*NW-1:0] s3_p_r [NPAIR];
  logic signed [2*NW-1:0] s3_q_r [NPAIR];

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_kind_r <= s2_kind_r;
      s3_px_r   <= s2_px_r;
      s3_py_r   <= s2_py_r;
      s3_rx_r   <= s2_rx_r;
      s3_ry_r   <= s2_ry_r;
      for (int e = 0; e < 4; e++) begin
        s3_n_r[e] <= s2_n_r[e];
        s3_d_r[e] <= s2_d_r[e];
      end
      for (int m = 0; m < NPAIR; m++) begin
        s3_p_r[m] <= (2*NW)'(s2_n_r[PAIR_A[m]]) * (2*NW)'(s2_d_r[PAIR_B[m]]);
        s3_q_r[m] <= (2*NW)'(s2_n_r[PAIR_B[m]]) * (2*NW)'(s2_d_r[PAIR_A[m]]);
      end
    end
  end

  // ---------------- stage 4: selection sort network, divider arguments
  logic                 s4_v_r;
  logic signed [CW-1:0] l0_base_r, l1_base_r;
  logic signed [NW-1:0] l0_num_r, l0_mul_r, l0_den_r;
  logic signed [NW-1:0] l1_num_r, l1_mul_r, l1_den_r;
  logic [T0W-1:0]       tag0_r;
  logic [1:0]           tag1_r;

  logic                 gt [4][4];
  edge_t                ord [4];
  edge_t                tmp;
  edge_t                esel [2];
  logic signed [CW-1:0] cbase [2];
  logic signed [NW-1:0] cnum [2];
  logic signed [NW-1:0] cmul [2];
  logic signed [NW-1:0] cden [2];
  logic                 case_a, side_hi;

  always_comb begin
    tmp = EDGE_TOP;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) gt[i][j] = 1'b0;
    for (int m = 0; m < NPAIR; m++) begin
      gt[PAIR_A[m]][PAIR_B[m]] = s3_p_r[m] > s3_q_r[m];
      gt[PAIR_B[m]][PAIR_A[m]] = s3_q_r[m] > s3_p_r[m];
    end
    ord[0] = EDGE_TOP;
    ord[1] = EDGE_RIGHT;
    ord[2] = EDGE_BOTTOM;
    ord[3] = EDGE_LEFT;
    for (int j = 0; j < 3; j++)
      for (int k = j + 1; k < 4; k++)
        if (gt[ord[j]][ord[k]]) begin
          tmp    = ord[j];
          ord[j] = ord[k];
          ord[k] = tmp;
        end
    esel[0] = ord[1];
    esel[1] = ord[2];
    for (int c = 0; c < 2; c++) begin
      cnum[c] = s3_n_r[esel[c]];
      cden[c] = s3_d_r[esel[c]];
      if (esel[c] == EDGE_TOP || esel[c] == EDGE_BOTTOM) begin
        cbase[c] = s3_px_r[CW-1:0];
        cmul[c]  = s3_rx_r;
      end else begin
        cbase[c] = s3_py_r[CW-1:0];
        cmul[c]  = s3_ry_r;
      end
    end
    case_a  = s3_px_r <= 0 || s3_px_r >= UNITV;
    side_hi = s3_px_r >= UNITV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_kind_r == KIND_CROSS) begin
        l0_base_r <= cbase[0];
        l0_num_r  <= cnum[0];
        l0_mul_r  <= cmul[0];
        l0_den_r  <= cden[0];
      end else begin
        // entry cut on the vertical side edge
        l0_base_r <= s3_py_r[CW-1:0];
        l0_num_r  <= (side_hi ? UNITV : '0) - s3_px_r;
        l0_mul_r  <= s3_ry_r;
        l0_den_r  <= s3_rx_r;
      end
      l1_base_r <= cbase[1];
      l1_num_r  <= cnum[1];
      l1_mul_r  <= cmul[1];
      l1_den_r  <= cden[1];
      tag0_r <= {s3_kind_r, s3_px_r[CW-1:0], s3_py_r[CW-1:0], s3_rx_r, s3_ry_r,
                 case_a, side_hi, s3_rx_r == '0, s3_ry_r == '0, esel[0]};
      tag1_r <= esel[1];
    end
  end

  // ---------------- first divider pair
  logic                 l0_ov, l1_ov;
  logic [T0W-1:0]       tag0_o;
  logic [1:0]           tag1_o;
  logic signed [CW-1:0] r0, r1;

  sucb_along #(.CW(CW), .TW(T0W)) u_lane0 (
    .clk, .rst_n, .en,
    .in_valid (s4_v_r),
    .in_tag   (tag0_r),
    .base     (l0_base_r),
    .num      (l0_num_r),
    .mul      (l0_mul_r),
    .den      (l0_den_r),
    .out_valid(l0_ov),
    .out_tag  (tag0_o),
    .result   (r0)
  );

  sucb_along #(.CW(CW), .TW(2)) u_lane1 (
    .clk, .rst_n, .en,
    .in_valid (s4_v_r),
    .in_tag   (tag1_r),
    .base     (l1_base_r),
    .num      (l1_num_r),
    .mul      (l1_mul_r),
    .den      (l1_den_r),
    .out_valid(l1_ov),
    .out_tag  (tag1_o),
    .result   (r1)
  );

  // ---------------- stage 5: cut check, crossing results, second-cut arguments
  logic [2:0]           k5_raw;
  crop_kind_t           k5;
  logic signed [CW-1:0] px5, py5;
  logic signed [NW-1:0] rx5, ry5;
  logic                 case_a5, side_hi5, vert5, horiz5;
  edge_t                e15;

  assign {k5_raw, px5, py5, rx5, ry5, case_a5, side_hi5, vert5, horiz5, e15} = tag0_o;
  assign k5 = crop_kind_t'(k5_raw);

  logic                 s5_v_r;
  logic signed [CW-1:0] l2_base_r;
  logic signed [NW-1:0] l2_num_r, l2_mul_r, l2_den_r;
  logic [T2W-1:0]       tag2_r;

  crop_kind_t           kn;
  logic signed [CW-1:0] fx, fy, sx, sy;
  logic                 use_y, ey_top, low, bad, hi;
  logic signed [NW-1:0] py5e, chk;
  logic signed [CW-1:0] px_c [2];
  logic signed [CW-1:0] py_c [2];
  logic signed [CW-1:0] rr;
  edge_t                ee;

  always_comb begin
    kn     = k5;
    fx     = '0;
    fy     = '0;
    sx     = '0;
    sy     = '0;
    use_y  = 1'b0;
    ey_top = 1'b0;
    low    = 1'b0;
    bad    = 1'b0;
    hi     = 1'b0;
    chk    = '0;
    rr     = '0;
    ee     = EDGE_TOP;
    py5e   = NW'(py5);
    for (int c = 0; c < 2; c++) begin
      px_c[c] = '0;
      py_c[c] = '0;
    end
    case (k5)
      KIND_CROP_START, KIND_CROP_END: begin
        low    = case_a5 ? (r0 < 0) : (py5 <= 0);
        ey_top = !low;
        use_y  = case_a5 && r0 >= 0 && r0 <= UNIT_C;
        if (use_y) begin
          fx = side_hi5 ? UNIT_C : '0;
          fy = r0;
        end
      end
      KIND_CROSS: begin
        if (vert5 && horiz5) begin
          kn = KIND_OUTSIDE;
        end else if (vert5) begin
          hi = py5 >= UNIT_C;
          fx = px5;
          sx = px5;
          fy = hi ? UNIT_C : '0;
          sy = hi ? '0 : UNIT_C;
        end else if (horiz5) begin
          hi = px5 >= UNIT_C;
          fy = py5;
          sy = py5;
          fx = hi ? UNIT_C : '0;
          sx = hi ? '0 : UNIT_C;
        end else begin
          for (int c = 0; c < 2; c++) begin
            rr  = (c == 0) ? r0 : r1;
            ee  = (c == 0) ? e15 : tag1_o;
            chk = NW'(rr);
            if (chk < -1 || chk > UNITV + 1) bad = 1'b1;
            if (ee == EDGE_TOP || ee == EDGE_BOTTOM) begin
              px_c[c] = rr;
              py_c[c] = (ee == EDGE_TOP) ? UNIT_C : '0;
            end else begin
              py_c[c] = rr;
              px_c[c] = (ee == EDGE_RIGHT) ? UNIT_C : '0;
            end
          end
          if (bad) begin
            kn = KIND_OUTSIDE;
          end else begin
            fx = px_c[0];
            fy = py_c[0];
            sx = px_c[1];
            sy = py_c[1];
          end
        end
      end
      default: begin
        kn = k5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (en) s5_v_r <= l0_ov;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // entry cut on the horizontal edge
      l2_base_r <= px5;
      l2_num_r  <= low ? -py5e : UNITV - py5e;
      l2_mul_r  <= rx5;
      l2_den_r  <= ry5;
      tag2_r    <= {kn, fx, fy, sx, sy, use_y, ey_top};
    end
  end

  // ---------------- second divider
  logic                 l2_ov;
  logic [T2W-1:0]       tag2_o;
  logic signed [CW-1:0] r2;

  sucb_along #(.CW(CW), .TW(T2W)) u_lane2 (
    .clk, .rst_n, .en,
    .in_valid (s5_v_r),
    .in_tag   (tag2_r),
    .base     (l2_base_r),
    .num      (l2_num_r),
    .mul      (l2_mul_r),
    .den      (l2_den_r),
    .out_valid(l2_ov),
    .out_tag  (tag2_o),
    .result   (r2)
  );

  // ---------------- output register
  logic [2:0]           k6_raw;
  crop_kind_t           k6;
  logic signed [CW-1:0] fx6, fy6, sx6, sy6;
  logic                 use_y6, ey_top6;

  assign {k6_raw, fx6, fy6, sx6, sy6, use_y6, ey_top6} = tag2_o;
  assign k6 = crop_kind_t'(k6_raw);

  logic                 out_v_r;
  crop_kind_t           out_kind_r;
  logic signed [CW-1:0] out_fx_r, out_fy_r, out_sx_r, out_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= l2_ov;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r <= k6;
      out_sx_r   <= sx6;
      out_sy_r   <= sy6;
      if ((k6 == KIND_CROP_START || k6 == KIND_CROP_END) && !use_y6) begin
        out_fx_r <= r2;
        out_fy_r <= ey_top6 ? UNIT_C : '0;
      end else begin
        out_fx_r <= fx6;
        out_fy_r <= fy6;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(ODW - 3 - 4 * CW){1'b0}},
                       out_sy_r, out_sx_r, out_fy_r, out_fx_r, out_kind_r};

  // ---------------- checks
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    l0_ov == l1_ov)
    else $error("divider lanes out of step");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_kind_r != KIND_CROSS |-> out_sx_r == '0 && out_sy_r == '0)
    else $error("second cut set for a non-crossing result");

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_kind_r == KIND_OUTSIDE || out_kind_r == KIND_INSIDE)
    |-> out_fx_r == '0 && out_fy_r == '0)
    else $error("first cut set for an uncut result");

  a_on_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_kind_r == KIND_CROP_START || out_kind_r == KIND_CROP_END ||
                   out_kind_r == KIND_CROSS)
    |-> out_fx_r == '0 || out_fx_r == UNIT_C || out_fy_r == '0 || out_fy_r == UNIT_C)
    else $error("first cut off the square border");

endmodule
